@@ sv/dcr_pkg.sv @@
// Shared constants, register indexes and fixed-point helpers for the
// depth-to-color registration core. No dependencies.
package dcr_pkg;

  localparam int PIX_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int TGT_W   = 13;
  localparam int SUB_W   = 16;

  typedef enum logic [2:0] {
    REG_DEPTH_FOCAL   = 3'd0,
    REG_DEPTH_CENTER  = 3'd1,
    REG_COLOR_FOCAL   = 3'd2,
    REG_COLOR_CENTER  = 3'd3,
    REG_RADIAL_K1_K2  = 3'd4,
    REG_TANGENTIAL    = 3'd5,
    REG_RADIAL_K3     = 3'd6,
    REG_COLOR_SIZE    = 3'd7
  } reg_index_t;

  // Depth-to-color rotation in millionths, row-major by source axis.
  localparam logic signed [20:0] ROT [9] = '{
    21'sd999970, 21'sd7027, 21'sd3347,
    -21'sd7092, 21'sd999780, 21'sd19726,
    -21'sd3208, -21'sd19749, 21'sd999800
  };

  // Translation in micrometres scaled by 256000.
  localparam logic signed [63:0] TRANS [3] = '{
    -64'sd14933504000, -64'sd100352000, -64'sd180736000
  };

  localparam logic signed [31:0] QONE    = 32'sh1000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return S32_MAX;
    else if (v < -66'sd2147483648) return S32_MIN;
    else return v[31:0];
  endfunction

  // Truncate a Q.16 pixel coordinate toward zero and saturate.
  function automatic logic signed [12:0] trunc_px(input logic signed [39:0] p);
    logic signed [39:0] mag;
    logic signed [39:0] v;
    mag = p[39] ? -p : p;
    v = p[39] ? -(mag >>> 16) : (mag >>> 16);
    if (v > 40'sd4095) return 13'sd4095;
    else if (v < -40'sd4096) return -13'sd4096;
    else return v[12:0];
  endfunction

  // Floor a Q.16 coordinate to Q.4 and saturate to 16 bits.
  function automatic logic signed [15:0] sub_px(input logic signed [39:0] p);
    logic signed [39:0] v;
    v = p >>> 12;
    if (v > 40'sd32767) return 16'sd32767;
    else if (v < -40'sd32768) return -16'sd32768;
    else return v[15:0];
  endfunction

endpackage

@@ sv/dcr_pixel_if.sv @@
// Depth pixel channel: valid/ready handshake plus pixel payload.
// Depends on dcr_pkg.
interface dcr_pixel_if import dcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_col;
  logic [PIX_W-1:0]   pixel_row;
  logic [DEPTH_W-1:0] depth_mm;

  modport source (output valid, output pixel_col, output pixel_row, output depth_mm,
                  input ready);
  modport sink (input valid, input pixel_col, input pixel_row, input depth_mm,
                output ready);
endinterface

@@ sv/dcr_result_if.sv @@
// Registration result channel: valid/ready handshake plus target payload.
// Depends on dcr_pkg.
interface dcr_result_if import dcr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TGT_W-1:0]  color_col;
  logic signed [TGT_W-1:0]  color_row;
  logic                     in_bounds;
  logic signed [SUB_W-1:0]  undist_col;
  logic signed [SUB_W-1:0]  undist_row;
  logic [DEPTH_W-1:0]       depth_out_mm;

  modport source (output valid, output color_col, output color_row, output in_bounds,
                  output undist_col, output undist_row, output depth_out_mm,
                  input ready);
  modport sink (input valid, input color_col, input color_row, input in_bounds,
                input undist_col, input undist_row, input depth_out_mm,
                output ready);
endinterface

@@ sv/depth_to_color_registration_core.sv @@
// Depth-to-color registration core: maps one depth pixel (column, row, depth
// in mm) to the color camera, with and without lens distortion.
// Depends on dcr_pkg, dcr_pixel_if, dcr_result_if and dcr_udiv.
//
// The core takes one pixel per clock and returns one result per pixel, in
// order. A result passes through two pairs of bit-serial pipelined dividers
// (41 stages for back-projection, 31 for the perspective divide) plus 28
// arithmetic stages, each at most one multiplier deep. A skid register sits
// behind the last stage: when the result sink stalls, one more pixel is still
// taken and the pipeline then holds; while the skid register drains, the input
// is held for that cycle. Write the camera registers only while the core is
// empty.
module depth_to_color_registration_core import dcr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [63:0]   wr_data,
  dcr_pixel_if.sink     pixel,
  dcr_result_if.source  result
);

  // ---------------------------------------------------------------- config
  logic [63:0] depth_focal;
  logic [63:0] depth_center;
  logic [63:0] color_focal;
  logic [63:0] color_center;
  logic [63:0] radial_k1_k2;
  logic [63:0] tangential_p1_p2;
  logic [31:0] radial_k3;
  logic [23:0] color_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_focal      <= '0;
      depth_center     <= '0;
      color_focal      <= '0;
      color_center     <= '0;
      radial_k1_k2     <= '0;
      tangential_p1_p2 <= '0;
      radial_k3        <= '0;
      color_size       <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_DEPTH_FOCAL:  depth_focal      <= wr_data;
        REG_DEPTH_CENTER: depth_center     <= wr_data;
        REG_COLOR_FOCAL:  color_focal      <= wr_data;
        REG_COLOR_CENTER: color_center     <= wr_data;
        REG_RADIAL_K1_K2: radial_k1_k2     <= wr_data;
        REG_TANGENTIAL:   tangential_p1_p2 <= wr_data;
        REG_RADIAL_K3:    radial_k3        <= wr_data[31:0];
        REG_COLOR_SIZE:   color_size       <= wr_data[23:0];
        default:          ;
      endcase
    end
  end

  logic [31:0] dfx, dfy, dcx, dcy, cfx, cfy, ccx, ccy;
  logic signed [31:0] k1, k2, k3, p1, p2;
  logic [11:0] cw, ch;

  assign dfx = depth_focal[63:32];
  assign dfy = depth_focal[31:0];
  assign dcx = depth_center[63:32];
  assign dcy = depth_center[31:0];
  assign cfx = color_focal[63:32];
  assign cfy = color_focal[31:0];
  assign ccx = color_center[63:32];
  assign ccy = color_center[31:0];
  assign k1  = $signed(radial_k1_k2[63:32]);
  assign k2  = $signed(radial_k1_k2[31:0]);
  assign k3  = $signed(radial_k3);
  assign p1  = $signed(tangential_p1_p2[63:32]);
  assign p2  = $signed(tangential_p1_p2[31:0]);
  assign cw  = color_size[23:12];
  assign ch  = color_size[11:0];

  // -------------------------------------------------------------- handshake
  // The whole pipeline advances together; only a full skid register holds it.
  // Take no pixel while reset is applied.
  logic skid_valid;
  logic ce;

  assign ce          = !skid_valid;
  assign pixel.ready = ce && !rst;

  // ---------------------------------------------------------- valid bits
  logic        v0, v1, v2, v3, vb4, vr1, vr2, vr3, vr4, vn0;
  logic [18:1] vld_d;
  logic        bdiv_valid, qdiv_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      vb4   <= 1'b0;
      vr1   <= 1'b0;
      vr2   <= 1'b0;
      vr3   <= 1'b0;
      vr4   <= 1'b0;
      vn0   <= 1'b0;
      vld_d <= '0;
    end else if (ce) begin
      v0    <= pixel.valid;
      v1    <= v0;
      v2    <= v1;
      v3    <= v2;
      vb4   <= bdiv_valid;
      vr1   <= vb4;
      vr2   <= vr1;
      vr3   <= vr2;
      vr4   <= vr3;
      vn0   <= qdiv_valid;
      vld_d <= {vld_d[17:1], vn0};
    end
  end

  // ------------------------------------------------------- back-projection
  logic [11:0]        col0, row0;
  logic [15:0]        dep0, dep1, dep2, dep3;
  logic signed [33:0] diffx1, diffy1;
  logic signed [50:0] numx2, numy2;
  logic [49:0]        absx2, absy2;
  logic [49:0]        magx3, magy3;
  logic               sgnx3, sgny3, ovfx3, ovfy3, inv3;

  assign absx2 = 50'(numx2[50] ? -numx2 : numx2);
  assign absy2 = 50'(numy2[50] ? -numy2 : numy2);

  always_ff @(posedge clk) begin
    if (ce) begin
      // capture the accepted pixel
      col0   <= pixel.pixel_col;
      row0   <= pixel.pixel_row;
      dep0   <= pixel.depth_mm;
      // offset from principal point, Q.16
      diffx1 <= $signed({6'b0, col0, 16'b0}) - $signed({2'b0, dcx});
      diffy1 <= $signed({6'b0, row0, 16'b0}) - $signed({2'b0, dcy});
      dep1   <= dep0;
      // scale by depth
      numx2  <= $signed({1'b0, dep1}) * diffx1;
      numy2  <= $signed({1'b0, dep1}) * diffy1;
      dep2   <= dep1;
      // split sign and magnitude; flag quotients that surely pass the clamp
      magx3  <= absx2;
      magy3  <= absy2;
      sgnx3  <= numx2[50];
      sgny3  <= numy2[50];
      ovfx3  <= {15'b0, absx2[49:33]} >= dfx;
      ovfy3  <= {15'b0, absy2[49:33]} >= dfy;
      inv3   <= (dep2 == '0) || (dfx == '0) || (dfy == '0);
      dep3   <= dep2;
    end
  end

  logic [40:0] bqx, bqy;
  logic [18:0] btagx;
  logic [1:0]  btagy;
  logic        by_valid;

  dcr_udiv #(.QW(41), .DW(32), .TW(19)) u_bdiv_x (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v3),
    .rem_init({15'b0, magx3[49:33]}), .den(dfx), .low_bits({magx3[32:0], 8'b0}),
    .tag_in({inv3, sgnx3, ovfx3, dep3}),
    .out_valid(bdiv_valid), .quo(bqx), .tag_out(btagx)
  );

  dcr_udiv #(.QW(41), .DW(32), .TW(2)) u_bdiv_y (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v3),
    .rem_init({15'b0, magy3[49:33]}), .den(dfy), .low_bits({magy3[32:0], 8'b0}),
    .tag_in({sgny3, ovfy3}),
    .out_valid(by_valid), .quo(bqy), .tag_out(btagy)
  );

  // clamp to 2^40 and restore the sign
  logic [40:0] clx, cly;
  assign clx = (btagx[16] || (bqx[40] && |bqx[39:0])) ? {1'b1, 40'b0} : bqx;
  assign cly = (btagy[0] || (bqy[40] && |bqy[39:0])) ? {1'b1, 40'b0} : bqy;

  logic signed [41:0] pinx4, piny4, pinz4;
  logic               inv4;
  logic [15:0]        dep4;

  // ---------------------------------------------------------- rigid motion
  logic signed [62:0] rprod [9];
  logic signed [63:0] s01 [3];
  logic signed [63:0] s2t [3];
  logic signed [63:0] pc3 [3];
  logic               invr1, invr2, invr3;
  logic [15:0]        depr1, depr2, depr3;

  logic [63:0] mx4, my4, dv4;
  logic        sgnx4, sgny4, satx4, saty4, invq4;
  logic [15:0] depq4;

  always_ff @(posedge clk) begin
    if (ce) begin
      pinx4 <= btagx[17] ? -$signed({1'b0, clx}) : $signed({1'b0, clx});
      piny4 <= btagy[1] ? -$signed({1'b0, cly}) : $signed({1'b0, cly});
      pinz4 <= $signed({18'b0, btagx[15:0], 8'b0});
      inv4  <= btagx[18];
      dep4  <= btagx[15:0];

      for (int i = 0; i < 3; i++) begin
        rprod[i]     <= ROT[i] * pinx4;
        rprod[i + 3] <= ROT[i + 3] * piny4;
        rprod[i + 6] <= ROT[i + 6] * pinz4;
      end
      invr1 <= inv4;
      depr1 <= dep4;

      for (int i = 0; i < 3; i++) begin
        s01[i] <= 64'(rprod[i]) + 64'(rprod[i + 3]);
        s2t[i] <= 64'(rprod[i + 6]) + TRANS[i];
      end
      invr2 <= invr1;
      depr2 <= depr1;

      for (int i = 0; i < 3; i++) begin
        pc3[i] <= s01[i] + s2t[i];
      end
      invr3 <= invr2;
      depr3 <= depr2;

      // prepare the perspective divide; drop points at or behind the camera
      mx4   <= 64'(pc3[0][63] ? -pc3[0] : pc3[0]);
      my4   <= 64'(pc3[1][63] ? -pc3[1] : pc3[1]);
      sgnx4 <= pc3[0][63];
      sgny4 <= pc3[1][63];
      dv4   <= pc3[2];
      satx4 <= {3'b0, 64'(pc3[0][63] ? -pc3[0] : pc3[0])} >= {pc3[2], 3'b0};
      saty4 <= {3'b0, 64'(pc3[1][63] ? -pc3[1] : pc3[1])} >= {pc3[2], 3'b0};
      invq4 <= invr3 || pc3[2][63] || (pc3[2] == '0);
      depq4 <= depr3;
    end
  end

  logic [30:0] qqx, qqy;
  logic [18:0] qtagx;
  logic [1:0]  qtagy;
  logic        qy_valid;

  dcr_udiv #(.QW(31), .DW(64), .TW(19)) u_qdiv_x (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(vr4),
    .rem_init({3'b0, mx4[63:3]}), .den(dv4), .low_bits({mx4[2:0], 28'b0}),
    .tag_in({invq4, sgnx4, satx4, depq4}),
    .out_valid(qdiv_valid), .quo(qqx), .tag_out(qtagx)
  );

  dcr_udiv #(.QW(31), .DW(64), .TW(2)) u_qdiv_y (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(vr4),
    .rem_init({3'b0, my4[63:3]}), .den(dv4), .low_bits({my4[2:0], 28'b0}),
    .tag_in({sgny4, saty4}),
    .out_valid(qy_valid), .quo(qqy), .tag_out(qtagy)
  );

  // ------------------------------------------------------------ distortion
  logic signed [31:0] nx0, ny0;
  logic               inv0;
  logic [15:0]        depn0;

  logic signed [31:0] nx_d [1:15];
  logic signed [31:0] ny_d [1:15];
  logic               inv_d [1:17];
  logic [15:0]        dep_d [1:17];
  logic signed [31:0] rr_d [2:12];
  logic signed [31:0] xd_d [10:14];
  logic signed [31:0] yd_d [10:14];

  logic [63:0]        sqx, sqy;
  logic signed [63:0] t3, t5, t7, px9, py9, pxy, pxx, pyy, m1, m2, m3, m4;
  logic signed [31:0] a1, a2, a3, xy, xx, yy, sx, sy, tx, ty, ex, ey;
  logic signed [64:0] pex, pey, pnx, pny;
  logic signed [39:0] pxc, pyc, pu, pv;
  logic [64:0]        sqsum;
  logic [36:0]        sqsh;

  logic signed [12:0] res_col, res_row;
  logic               res_inb;
  logic signed [15:0] res_ucol, res_urow;
  logic [15:0]        res_dep;

  assign sqsum = {1'b0, sqx} + {1'b0, sqy};
  assign sqsh  = sqsum[64:28];

  always_ff @(posedge clk) begin
    if (ce) begin
      // normalized coordinates, Q4.28
      nx0   <= qtagx[16] ? (qtagx[17] ? S32_MIN : S32_MAX)
                         : (qtagx[17] ? -$signed({1'b0, qqx}) : $signed({1'b0, qqx}));
      ny0   <= qtagy[0] ? (qtagy[1] ? S32_MIN : S32_MAX)
                        : (qtagy[1] ? -$signed({1'b0, qqy}) : $signed({1'b0, qqy}));
      inv0  <= qtagx[18];
      depn0 <= qtagx[15:0];

      nx_d[1]  <= nx0;
      ny_d[1]  <= ny0;
      inv_d[1] <= inv0;
      dep_d[1] <= depn0;
      for (int k = 2; k <= 15; k++) begin
        nx_d[k] <= nx_d[k - 1];
        ny_d[k] <= ny_d[k - 1];
      end
      for (int k = 2; k <= 17; k++) begin
        inv_d[k] <= inv_d[k - 1];
        dep_d[k] <= dep_d[k - 1];
      end
      for (int k = 3; k <= 12; k++) begin
        rr_d[k] <= rr_d[k - 1];
      end
      for (int k = 11; k <= 14; k++) begin
        xd_d[k] <= xd_d[k - 1];
        yd_d[k] <= yd_d[k - 1];
      end

      // r^2 from the magnitudes
      sqx <= 32'(nx0[31] ? -nx0 : nx0) * 32'(nx0[31] ? -nx0 : nx0);
      sqy <= 32'(ny0[31] ? -ny0 : ny0) * 32'(ny0[31] ? -ny0 : ny0);
      rr_d[2] <= (|sqsh[36:31]) ? S32_MAX : $signed(sqsh[31:0]);

      // radial factor, Horner form
      t3 <= rr_d[2] * k3;
      a1 <= sat32(66'(k2) + 66'(t3 >>> 28));
      t5 <= rr_d[4] * a1;
      a2 <= sat32(66'(k1) + 66'(t5 >>> 28));
      t7 <= rr_d[6] * a2;
      a3 <= sat32(66'(QONE) + 66'(t7 >>> 28));

      // radially scaled coordinates
      px9 <= nx_d[8] * a3;
      py9 <= ny_d[8] * a3;
      xd_d[10] <= sat32(66'(px9 >>> 28));
      yd_d[10] <= sat32(66'(py9 >>> 28));

      // tangential terms
      pxy <= xd_d[10] * yd_d[10];
      pxx <= xd_d[10] * xd_d[10];
      pyy <= yd_d[10] * yd_d[10];
      xy  <= sat32(66'(pxy >>> 28));
      xx  <= sat32(66'(pxx >>> 28));
      yy  <= sat32(66'(pyy >>> 28));
      m1  <= p1 * xy;
      m2  <= p2 * xy;
      sx  <= sat32(66'(rr_d[12]) + (66'(xx) <<< 1));
      sy  <= sat32(66'(rr_d[12]) + (66'(yy) <<< 1));
      tx  <= sat32(66'(m1 >>> 28) <<< 1);
      ty  <= sat32(66'(m2 >>> 28) <<< 1);
      m3  <= p2 * sx;
      m4  <= p1 * sy;
      ex  <= sat32(66'(xd_d[14]) + 66'(tx) + 66'(m3 >>> 28));
      ey  <= sat32(66'(yd_d[14]) + 66'(ty) + 66'(m4 >>> 28));

      // projection into the color camera, Q.16
      pex <= ex * $signed({1'b0, cfx});
      pey <= ey * $signed({1'b0, cfy});
      pnx <= nx_d[15] * $signed({1'b0, cfx});
      pny <= ny_d[15] * $signed({1'b0, cfy});
      pxc <= 40'(pex >>> 28) + $signed({8'b0, ccx});
      pyc <= 40'(pey >>> 28) + $signed({8'b0, ccy});
      pu  <= 40'(pnx >>> 28) + $signed({8'b0, ccx});
      pv  <= 40'(pny >>> 28) + $signed({8'b0, ccy});

      // final formatting; invalid points report zero coordinates, the depth passes
      res_dep <= dep_d[17];
      if (inv_d[17]) begin
        res_col  <= '0;
        res_row  <= '0;
        res_inb  <= 1'b0;
        res_ucol <= '0;
        res_urow <= '0;
      end else begin
        res_col  <= trunc_px(pxc);
        res_row  <= trunc_px(pyc);
        res_inb  <= !pxc[39] && (pxc < $signed({12'b0, cw, 16'b0})) &&
                    !pyc[39] && (pyc < $signed({12'b0, ch, 16'b0}));
        res_ucol <= sub_px(pu);
        res_urow <= sub_px(pv);
      end
    end
  end

  // ------------------------------------------------------------ skid stage
  logic signed [12:0] skid_col, skid_row;
  logic               skid_inb;
  logic signed [15:0] skid_ucol, skid_urow;
  logic [15:0]        skid_dep;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) skid_valid <= 1'b0;
    end else if (vld_d[18] && !result.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_col  <= res_col;
      skid_row  <= res_row;
      skid_inb  <= res_inb;
      skid_ucol <= res_ucol;
      skid_urow <= res_urow;
      skid_dep  <= res_dep;
    end
  end

  assign result.valid        = skid_valid || vld_d[18];
  assign result.color_col    = skid_valid ? skid_col  : res_col;
  assign result.color_row    = skid_valid ? skid_row  : res_row;
  assign result.in_bounds    = skid_valid ? skid_inb  : res_inb;
  assign result.undist_col   = skid_valid ? skid_ucol : res_ucol;
  assign result.undist_row   = skid_valid ? skid_urow : res_urow;
  assign result.depth_out_mm = skid_valid ? skid_dep  : res_dep;

endmodule

@@ sv/dcr_udiv.sv @@
// Pipelined restoring divider, one quotient bit per register stage, with a
// tag that travels alongside. Depends on nothing.
module dcr_udiv #(
  parameter int QW = 31,
  parameter int DW = 64,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [DW-1:0] rem_init,
  input  logic [DW-1:0] den,
  input  logic [QW-1:0] low_bits,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  logic          vld [1:QW];
  logic [DW-1:0] rem [1:QW];
  logic [DW-1:0] dvs [1:QW];
  logic [QW-1:0] low [1:QW];
  logic [QW-1:0] q   [1:QW];
  logic [TW-1:0] tag [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic          src_vld;
    logic [DW-1:0] src_rem;
    logic [DW-1:0] src_dvs;
    logic [QW-1:0] src_low;
    logic [QW-1:0] src_q;
    logic [TW-1:0] src_tag;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = rem_init;
      assign src_dvs = den;
      assign src_low = low_bits;
      assign src_q   = '0;
      assign src_tag = tag_in;
    end else begin : g_next
      assign src_vld = vld[i];
      assign src_rem = rem[i];
      assign src_dvs = dvs[i];
      assign src_low = low[i];
      assign src_q   = q[i];
      assign src_tag = tag[i];
    end

    // Shift in the next dividend bit and subtract where it fits.
    assign trial = {src_rem, src_low[QW-1]};
    assign diff  = trial - {1'b0, src_dvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (ce) begin
        vld[i+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i+1] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        dvs[i+1] <= src_dvs;
        low[i+1] <= src_low << 1;
        q[i+1]   <= {src_q[QW-2:0], ~diff[DW]};
        tag[i+1] <= src_tag;
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign tag_out   = tag[QW];

endmodule

@@ sv/dcr_checker.sv @@
// Port-level checks for the depth-to-color registration core, bound to it.
// Depends on depth_to_color_registration_core.
module dcr_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [12:0] color_col,
  input logic signed [12:0] color_row,
  input logic               in_bounds,
  input logic signed [15:0] undist_col,
  input logic signed [15:0] undist_row,
  input logic [15:0]        depth_out_mm
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_col) && $stable(color_row)
      && $stable(in_bounds) && $stable(undist_col) && $stable(depth_out_mm))
    else $error("stalled result changed");

  a_no_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_out_mm == 16'd0 |-> !in_bounds && color_col == 13'sd0
      && color_row == 13'sd0 && undist_col == 16'sd0 && undist_row == 16'sd0)
    else $error("zero depth gave a target");

  a_bounds_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_bounds |-> !color_col[12] && !color_row[12])
    else $error("in-bounds target has a negative coordinate");

endmodule

bind depth_to_color_registration_core dcr_checker u_dcr_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .color_col(result.color_col),
  .color_row(result.color_row),
  .in_bounds(result.in_bounds),
  .undist_col(result.undist_col),
  .undist_row(result.undist_row),
  .depth_out_mm(result.depth_out_mm)
);
